FILE: hdl/four_level_page_table_mapper_assert.svh
// ----------------------------------------------------------------------------
// four_level_page_table_mapper_assert.svh
// Assertion macros shared by the checker of the page table mapper.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FPTM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fptm: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define FPTM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fptm: next-cycle check failed");

`endif

FILE: hdl/fptm_pkg.sv
// ----------------------------------------------------------------------------
// fptm_pkg
// Types, constants and helpers shared by the page table mapper modules.
// ----------------------------------------------------------------------------
package fptm_pkg;

  // Default size of the table frame pool.
  localparam int POOL_FRAMES_DEF = 16;

  // Fixed geometry of one table frame and of the entry fields.
  localparam int TABLE_ENTRIES = 512;
  localparam int IDX_W         = 9;
  localparam int VA_W          = 48;
  localparam int PA_W          = 52;
  localparam int FLAG_W        = 12;
  localparam int FRAME_W       = 40;
  localparam int ENTRY_W       = 52;
  localparam int ADDED_W       = 3;
  localparam int UPPER_LEVELS  = 3;
  localparam int LVL_W         = 2;

  // Result status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_FRAME = 1'b1;

  // Leaf level number (the fourth level).
  localparam logic [LVL_W-1:0] LEAF_LEVEL = 2'd3;

  typedef struct packed {
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_addr;
    logic [FLAG_W-1:0] page_flags;
  } map_req_t;

  typedef struct packed {
    logic               status;
    logic [ADDED_W-1:0] tables_added;
    logic [ENTRY_W-1:0] leaf_entry;
  } map_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DECIDE,
    ST_LINK,
    ST_LEAF,
    ST_FINISH
  } fptm_state_t;

  // Picks the 9-bit table index of one level out of the virtual address.
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

FILE: hdl/four_level_page_table_mapper.sv
// ----------------------------------------------------------------------------
// four_level_page_table_mapper
// Inserts one 4 KiB page mapping per request into a four-level radix page
// table whose frames live in an on-chip store, taking new table frames from
// a bump allocator.
//
//   channel  signals                          direction  payload
//   map      map_valid / map_ready / map_req  in         map_req_t
//   res      res_valid / res_ready / res      out        map_res_t
//   cfg      cfg_valid / cfg_ready / cfg_data in         pool base frame
//
// A map goes through up to three read-and-check steps on the single-ported
// table store, one pool check, one pointer write per new table below the
// root, and the leaf write; a refused one ends at the failing range check
// or pool check.
// One 40-bit adder serves both the pointer range check and the new frame
// address. After reset the store is swept to zero, one entry a cycle, over
// all POOL_FRAMES * 512 entries, and no request is accepted meanwhile.
// The next request is taken while a result still waits on the res channel;
// it stalls only at its own result until that beat has gone.
// ----------------------------------------------------------------------------
module four_level_page_table_mapper #(
  parameter int POOL_FRAMES = fptm_pkg::POOL_FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             map_valid,
  output logic                             map_ready,
  input  fptm_pkg::map_req_t               map_req,
  output logic                             res_valid,
  input  logic                             res_ready,
  output fptm_pkg::map_res_t               res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fptm_pkg::FRAME_W-1:0]     cfg_data
);
  import fptm_pkg::*;

  localparam int FIW = $clog2(POOL_FRAMES);
  localparam int FUW = $clog2(POOL_FRAMES + 1);
  localparam int AW  = FIW + IDX_W;
  localparam int CW  = FUW + ADDED_W;

  fptm_state_t        state, state_next;
  map_req_t           req, req_next;
  logic [LVL_W-1:0]   lvl, lvl_next;
  logic [FIW-1:0]     cur, cur_next;
  logic [FUW-1:0]     frames_used, frames_used_next;
  logic [ADDED_W-1:0] need, need_next;
  logic               err, err_next;
  logic [FRAME_W-1:0] pool_base_frame;

  logic               store_busy;
  logic               wr_en, rd_en;
  logic [AW-1:0]      st_addr;
  logic [ENTRY_W-1:0] wr_data, rd_data;

  logic               alu_sub;
  logic [FRAME_W-1:0] alu_a, alu_b, alu_sum;
  logic               rel_ok;
  logic [FLAG_W-1:0]  flags_eff;
  logic [ENTRY_W-1:0] leaf_val;
  logic [ADDED_W-1:0] need_calc;
  logic               pool_short;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base_frame <= '0;
    end else if (cfg_valid) begin
      pool_base_frame <= cfg_data;
    end
  end

  // Shared frame adder: entry frame minus base while checking, base plus
  // the next free frame while linking a new table.
  assign alu_sub = (state == ST_CHECK);
  assign alu_a   = alu_sub ? rd_data[ENTRY_W-1:FLAG_W] : pool_base_frame;
  assign alu_b   = alu_sub ? ~pool_base_frame : FRAME_W'(frames_used);
  assign alu_sum = alu_a + alu_b + FRAME_W'(alu_sub);
  assign rel_ok  = alu_sum < FRAME_W'(frames_used);

  // Entry values and the frame count needed by this request.
  assign flags_eff  = req.page_flags | FLAG_W'(1);
  assign leaf_val   = req.phys_addr | ENTRY_W'(flags_eff);
  assign need_calc  = ADDED_W'(UPPER_LEVELS) - ADDED_W'(lvl)
                    + ADDED_W'(frames_used == '0);
  assign pool_short = (CW'(frames_used) + CW'(need_calc)) > CW'(POOL_FRAMES);

  // Store port drive: one address serves reads and writes.
  assign st_addr = {cur, level_index(req.virt_addr, lvl)};
  assign rd_en   = (state == ST_READ);
  assign wr_en   = (state == ST_LINK) || (state == ST_LEAF);
  assign wr_data = (state == ST_LEAF) ? leaf_val : {alu_sum, flags_eff};

  assign map_ready = (state == ST_IDLE) && !store_busy;

  fptm_store #(
    .POOL_FRAMES (POOL_FRAMES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (st_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (st_addr),
    .rd_data (rd_data),
    .busy    (store_busy)
  );

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      frames_used <= '0;
    end else begin
      state       <= state_next;
      frames_used <= frames_used_next;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    req  <= req_next;
    lvl  <= lvl_next;
    cur  <= cur_next;
    need <= need_next;
    err  <= err_next;
  end

  // Result register: loaded when the walk finishes, held until its beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_FINISH && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!res_valid || res_ready)) begin
      if (err) begin
        res <= '{status: STATUS_NO_FRAME, tables_added: '0, leaf_entry: '0};
      end else begin
        res <= '{status: STATUS_OK, tables_added: need, leaf_entry: leaf_val};
      end
    end
  end

  // Sequencer: walk the upper levels, check the pool, then write.
  always_comb begin
    state_next       = state;
    req_next         = req;
    lvl_next         = lvl;
    cur_next         = cur;
    frames_used_next = frames_used;
    need_next        = need;
    err_next         = err;
    case (state)
      ST_IDLE: begin
        if (map_valid && map_ready) begin
          req_next   = map_req;
          lvl_next   = '0;
          cur_next   = '0;
          err_next   = 1'b0;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        // An absent entry ends the walk; a present one must point into
        // the part of the pool already taken.
        if (!rd_data[0]) begin
          state_next = ST_DECIDE;
        end else if (rel_ok) begin
          cur_next   = alu_sum[FIW-1:0];
          lvl_next   = lvl + LVL_W'(1);
          state_next = (lvl == LVL_W'(UPPER_LEVELS - 1)) ? ST_DECIDE : ST_READ;
        end else begin
          err_next   = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_DECIDE: begin
        if (pool_short) begin
          err_next   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          need_next = need_calc;
          // The root is frame zero, taken by the first map.
          if (frames_used == '0) begin
            frames_used_next = FUW'(1);
          end
          state_next = (lvl == LEAF_LEVEL) ? ST_LEAF : ST_LINK;
        end
      end
      ST_LINK: begin
        cur_next         = frames_used[FIW-1:0];
        frames_used_next = frames_used + FUW'(1);
        lvl_next         = lvl + LVL_W'(1);
        state_next       = (lvl == LVL_W'(UPPER_LEVELS - 1)) ? ST_LEAF : ST_LINK;
      end
      ST_LEAF: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!res_valid || res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/fptm_store.sv
// ----------------------------------------------------------------------------
// fptm_store
// Table frame store: one write port, one read port with registered data,
// and a clearing sweep over every entry after reset.
// ----------------------------------------------------------------------------
module fptm_store #(
  parameter int POOL_FRAMES = fptm_pkg::POOL_FRAMES_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    wr_en,
  input  logic [$clog2(POOL_FRAMES)+fptm_pkg::IDX_W-1:0]          wr_addr,
  input  logic [fptm_pkg::ENTRY_W-1:0]                            wr_data,
  input  logic                                                    rd_en,
  input  logic [$clog2(POOL_FRAMES)+fptm_pkg::IDX_W-1:0]          rd_addr,
  output logic [fptm_pkg::ENTRY_W-1:0]                            rd_data,
  output logic                                                    busy
);
  import fptm_pkg::*;

  localparam int AW    = $clog2(POOL_FRAMES) + IDX_W;
  localparam int DEPTH = POOL_FRAMES * TABLE_ENTRIES;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [AW-1:0]      clr_addr;

  // Clearing sweep: one entry a cycle from address zero up to the last entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      busy     <= 1'b1;
    end else if (busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Write port, taken over by the sweep while it runs.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/fptm_checker.sv
// ----------------------------------------------------------------------------
// fptm_checker
// Port-level checks of the page table mapper, bound to its top level.
// ----------------------------------------------------------------------------
`include "four_level_page_table_mapper_assert.svh"

module fptm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         map_valid,
  input logic                         map_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input fptm_pkg::map_res_t           res
);
  import fptm_pkg::*;

  logic res_bad, res_good, res_empty;

  // Result status decoded once for the checks below.
  assign res_bad   = res_valid && res.status == STATUS_NO_FRAME;
  assign res_good  = res_valid && res.status == STATUS_OK;
  assign res_empty = res.tables_added == '0 && res.leaf_entry == '0;

  // A failed map reports no tables and an empty leaf.
  `FPTM_ASSERT_IMP(a_err_empty, clk, rst, res_bad, res_empty)

  // A good map always writes a present leaf.
  `FPTM_ASSERT_IMP(a_leaf_present, clk, rst, res_good, res.leaf_entry[0])

  // At most the root and three lower tables come from one map.
  `FPTM_ASSERT_IMP(a_added_range, clk, rst, res_valid, res.tables_added <= 3'd4)

  // The block works on one request at a time.
  `FPTM_ASSERT_NXT(a_one_at_a_time, clk, rst, map_valid && map_ready, !map_ready)

  // A stalled result beat holds.
  `FPTM_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res))

endmodule

bind four_level_page_table_mapper fptm_checker u_fptm_checker (.*);

FILE: tb/four_level_page_table_mapper_tb.sv
// ----------------------------------------------------------------------------
// four_level_page_table_mapper_tb
// Self-checking bench for the four-level page table mapper. A mirror of the
// table store and of the frame allocator predicts each result. Directed walks
// fill the pool up to and beyond its limit. Random requests then mostly reuse
// the paths already built, under several pool base settings, with random
// stalls on both channels.
// ----------------------------------------------------------------------------
module four_level_page_table_mapper_tb;
  import fptm_pkg::*;

  localparam int POOL_FRAMES = POOL_FRAMES_DEF;
  localparam int SETTLE_CYCLES = 16;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                map_valid = 1'b0;
  logic                map_ready;
  map_req_t            map_req   = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  map_res_t            res;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [FRAME_W-1:0]  cfg_data  = '0;

  // Mirror of the table store, the allocator and the pool base register.
  logic [ENTRY_W-1:0]  pt_mirror [POOL_FRAMES*TABLE_ENTRIES];
  int                  mirror_frames_used = 0;
  logic [FRAME_W-1:0]  mirror_pool_base   = '0;

  // Results still owed by the block, oldest first.
  map_res_t            expected_results [$];
  // Virtual address bits 47..21 of every path that took new tables.
  logic [26:0]         mapped_prefixes [$];

  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  mismatches    = 0;

  four_level_page_table_mapper #(
    .POOL_FRAMES(POOL_FRAMES)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .map_valid (map_valid),
    .map_ready (map_ready),
    .map_req   (map_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // A present entry is followed only if its frame lies in the used part of
  // the pool, reckoned from the current base with 40-bit wrap.
  function automatic bit frame_in_pool(input logic [ENTRY_W-1:0] entry,
                                       output int frame);
    logic [FRAME_W-1:0] rel;
    rel   = entry[ENTRY_W-1:12] - mirror_pool_base;
    frame = 0;
    if (rel >= FRAME_W'(mirror_frames_used) || rel >= FRAME_W'(POOL_FRAMES))
      return 1'b0;
    frame = int'(rel);
    return 1'b1;
  endfunction

  // Works out the result of one mapping and applies its writes to the mirror.
  function automatic map_res_t predict_mapping(input map_req_t r);
    logic [IDX_W-1:0]   ix [4];
    logic [FLAG_W-1:0]  flg;
    logic [ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0] leaf;
    map_res_t           outcome;
    int                 need;
    int                 cur;
    int                 nx;
    int                 present;
    int                 pos;
    bit                 bad;
    bit                 stop;
    ix[0]   = r.virt_addr[47:39];
    ix[1]   = r.virt_addr[38:30];
    ix[2]   = r.virt_addr[29:21];
    ix[3]   = r.virt_addr[20:12];
    flg     = {r.page_flags[FLAG_W-1:1], 1'b1};
    need    = 0;
    cur     = 0;
    present = 0;
    bad     = 1'b0;
    stop    = 1'b0;

    // Count the frames needed before anything is written.
    if (mirror_frames_used == 0) begin
      need = 1;
    end else begin
      for (int lvl = 0; lvl < UPPER_LEVELS && !stop; lvl++) begin
        entry = pt_mirror[cur*TABLE_ENTRIES + int'(ix[lvl])];
        if (!entry[0]) begin
          stop = 1'b1;
        end else if (!frame_in_pool(entry, nx)) begin
          bad  = 1'b1;
          stop = 1'b1;
        end else begin
          cur = nx;
          present++;
        end
      end
    end
    need += UPPER_LEVELS - present;

    if (bad || mirror_frames_used + need > POOL_FRAMES) begin
      outcome.status       = STATUS_NO_FRAME;
      outcome.tables_added = '0;
      outcome.leaf_entry   = '0;
      return outcome;
    end

    // Walk again, linking a fresh frame wherever an entry cannot be followed.
    if (mirror_frames_used == 0)
      mirror_frames_used = 1;
    cur = 0;
    for (int lvl = 0; lvl < UPPER_LEVELS; lvl++) begin
      pos   = cur*TABLE_ENTRIES + int'(ix[lvl]);
      entry = pt_mirror[pos];
      if (entry[0] && frame_in_pool(entry, nx)) begin
        cur = nx;
      end else begin
        nx = mirror_frames_used;
        mirror_frames_used++;
        pt_mirror[pos] = {mirror_pool_base + FRAME_W'(nx), flg};
        cur = nx;
      end
    end
    leaf = r.phys_addr | {{(ENTRY_W-FLAG_W){1'b0}}, flg};
    pt_mirror[cur*TABLE_ENTRIES + int'(ix[3])] = leaf;
    if (need != 0)
      mapped_prefixes.push_back(r.virt_addr[47:21]);
    outcome.status       = STATUS_OK;
    outcome.tables_added = ADDED_W'(need);
    outcome.leaf_entry   = leaf;
    return outcome;
  endfunction

  // Sends one request beat, idling first at random, and records its result.
  task automatic send_mapping(input map_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      map_valid <= 1'b0;
      @(posedge clk);
    end
    map_valid <= 1'b1;
    map_req   <= r;
    @(posedge clk);
    while (!map_ready) @(posedge clk);
    expected_results.push_back(predict_mapping(r));
  endtask

  task automatic send_directed(input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
                               input logic [FLAG_W-1:0] flags);
    map_req_t r;
    r.virt_addr  = va;
    r.phys_addr  = pa;
    r.page_flags = flags;
    send_mapping(r);
  endtask

  // Random requests: most follow a path already built, the rest branch off
  // it at a higher level or land anywhere in the address space.
  task automatic send_random(input int count);
    map_req_t    r;
    logic [26:0] prefix;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick        = $urandom_range(99);
      r.virt_addr = {16'($urandom), $urandom};
      if (mapped_prefixes.size() != 0) begin
        prefix = mapped_prefixes[$urandom_range(mapped_prefixes.size() - 1)];
        if (pick < 70)
          r.virt_addr[47:21] = prefix;
        else if (pick < 80)
          r.virt_addr[47:30] = prefix[26:9];
        else if (pick < 88)
          r.virt_addr[47:39] = prefix[26:18];
      end
      r.phys_addr = PA_W'({$urandom, $urandom});
      if ($urandom_range(4) != 0)
        r.phys_addr[11:0] = '0;
      r.page_flags = FLAG_W'($urandom_range(4095));
      send_mapping(r);
    end
  endtask

  // Writes the pool base; only called while no request is in flight.
  task automatic write_pool_base(input logic [FRAME_W-1:0] base);
    cfg_valid <= 1'b1;
    cfg_data  <= base;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mirror_pool_base = base;
  endtask

  // Stops sending and waits until every owed result has come back.
  task automatic settle_idle();
    map_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result checker; it also drives the receiver's stalls.
  always @(posedge clk) begin
    map_res_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no mapping outstanding");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (res.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res.status);
          mismatches++;
        end
        if (res.tables_added !== want.tables_added) begin
          $error("tables_added: expected %0d, got %0d", want.tables_added,
                 res.tables_added);
          mismatches++;
        end
        if (res.leaf_entry !== want.leaf_entry) begin
          $error("leaf_entry: expected %h, got %h", want.leaf_entry, res.leaf_entry);
          mismatches++;
        end
      end
    end
    res_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Builds paths with the base at its top value, so frame numbers wrap, and
  // drives the pool to its exact limit and past it.
  task automatic test_directed_walks();
    write_pool_base('1);
    send_directed('0, '0, '0);
    send_directed('0, '1, '1);
    send_directed('1, 52'hF_FFFF_FFFF_F000, 12'h0A5);
    // Unaligned physical address; low bits of the virtual address ignored.
    send_directed(48'h0000_0000_1FFF, 52'h1_2345_6789_ABCD, 12'h800);
    send_directed(48'h0000_0020_0000, 52'h0_0000_0ABC_D000, 12'h003);
    send_directed(48'h0000_4000_0000, 52'h8_0000_0000_1000, 12'hFFE);
    send_directed(48'h0080_0000_0000, 52'h0_5555_5555_5000, 12'h555);
    send_directed(48'h0080_4000_0000, 52'hA_AAAA_AAAA_A000, 12'hAAA);
    // Three tables wanted, one frame left: refused.
    send_directed(48'h7FFF_FFFF_F000, 52'h0_0000_1234_5000, 12'h001);
    // One table wanted, one frame left: the pool fills exactly.
    send_directed(48'h0000_0040_0000, 52'h0_0000_0000_7000, 12'h00F);
    send_directed(48'h0000_0060_0000, 52'h0_0000_0000_8000, 12'h010);
    send_directed('1, 52'h0_0000_0000_0001, 12'h7FF);
    settle_idle();
  endtask

  task automatic test_random_fill();
    send_random(300);
    settle_idle();
  endtask

  // Base at zero: every stored pointer now names the frame below its own.
  task automatic test_shifted_pool();
    write_pool_base('0);
    send_random(250);
    settle_idle();
  endtask

  // Base far from the stored pointers: every present entry lies outside.
  task automatic test_foreign_pointers();
    write_pool_base({1'b1, 7'($urandom), $urandom});
    send_directed('0, 52'h0_0000_0000_9000, 12'h001);
    send_directed('1, 52'h0_0000_0000_A000, 12'h001);
    send_random(50);
    settle_idle();
  endtask

  task automatic test_restored_pool();
    write_pool_base('1);
    send_random(250);
    settle_idle();
  endtask

  initial begin
    foreach (pt_mirror[i]) pt_mirror[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 70;
    test_directed_walks();
    test_random_fill();
    send_idle_pct = 70;
    recv_idle_pct = 30;
    test_shifted_pool();
    test_foreign_pointers();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_restored_pool();
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
